// ===== src/smrs_pkg.sv =====
// Package for the sensor measurement retry sequencer.
// Holds the field widths, register indexes and action codes. No dependencies.
package smrs_pkg;

  localparam int unsigned DelayW  = 16;
  localparam int unsigned RetryW  = 8;
  localparam int unsigned ActionW = 3;
  localparam int unsigned StateW  = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [DelayW-1:0] IdleDelayRst    = 16'd50;
  localparam logic [DelayW-1:0] MeasureDelayRst = 16'd20;
  localparam logic [RetryW-1:0] MaxRetriesRst   = 8'd3;
  localparam logic [RetryW-1:0] RetrySat        = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    CfgIdleDelay    = 2'd0,
    CfgMeasureDelay = 2'd1,
    CfgMaxRetries   = 2'd2
  } cfg_idx_e;

  typedef enum logic [ActionW-1:0] {
    ActNone      = 3'd0,
    ActStart     = 3'd1,
    ActRead      = 3'd2,
    ActCrc       = 3'd3,
    ActConvert   = 3'd4,
    ActSoftReset = 3'd5
  } action_e;

endpackage

// ===== src/sensor_measure_retry_sequencer.sv =====
// Sensor measurement retry sequencer: one step of the measurement state machine
// per input transfer, one result transfer per step. Depends on smrs_pkg.
//
// channel | direction | handshake               | payload
// --------+-----------+-------------------------+--------------------------------------
// in      | input     | in_valid_i / in_ready_o | ms_tick_i, bus_ok_i, check_ok_i
// out     | output    | out_valid_o/out_ready_i | action_o, state_now_o, system_fault_o,
//         |           |                         | disabled_o
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One step per cycle unless the output stalls: an input register feeds the state
// update, whose result is registered in the output register.
// Both stages advance together whenever the output register is free or taken,
// so a stalled output holds the input stage and then in_ready_o.
// Reset clears the state machine, counters, valid flags and config registers to
// defaults; the first idle after reset carries no delay. Configuration is always ready.
module sensor_measure_retry_sequencer
  import smrs_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               ms_tick_i,
  input  logic               bus_ok_i,
  input  logic               check_ok_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ActionW-1:0] action_o,
  output logic [StateW-1:0]  state_now_o,
  output logic               system_fault_o,
  output logic               disabled_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DelayW-1:0]  cfg_data_i
);

  typedef enum logic [StateW-1:0] {
    StIdle     = 4'd0,
    StStart    = 4'd1,
    StWait     = 4'd2,
    StRead     = 4'd3,
    StCrc      = 4'd4,
    StCalc     = 4'd5,
    StRestart  = 4'd6,
    StError    = 4'd7,
    StDisabled = 4'd8
  } state_e;

  logic [DelayW-1:0]     idle_delay_q, measure_delay_q;
  logic [RetryW-1:0]     max_retries_q;

  logic                  s1_valid_q;
  logic                  s1_tick_q, s1_bus_ok_q, s1_check_ok_q;
  logic                  s1_adv;

  state_e                state_q, state_d, prev_q;
  logic [TIMER_BITS-1:0] delay_q, delay_d;
  logic [RetryW-1:0]     retry_q, retry_d, retry_inc;
  action_e               action_d;
  logic                  fault_d;

  logic                  out_valid_q;
  logic [ActionW-1:0]    action_q;
  logic [StateW-1:0]     state_now_q;
  logic                  fault_q, disabled_q;

  function automatic logic [TIMER_BITS-1:0] clamp_delay(input logic [DelayW-1:0] ms);
    logic ovf;
    ovf = (ms >> TIMER_BITS) != '0;
    return ovf ? '1 : TIMER_BITS'(ms);
  endfunction

  assign cfg_ready_o = 1'b1;
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_delay_q    <= IdleDelayRst;
      measure_delay_q <= MeasureDelayRst;
      max_retries_q   <= MaxRetriesRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgIdleDelay:    idle_delay_q    <= cfg_data_i;
        CfgMeasureDelay: measure_delay_q <= cfg_data_i;
        CfgMaxRetries:   max_retries_q   <= cfg_data_i[RetryW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_tick_q     <= ms_tick_i;
      s1_bus_ok_q   <= bus_ok_i;
      s1_check_ok_q <= check_ok_i;
    end
  end

  always_comb begin
    delay_d   = delay_q;
    retry_d   = retry_q;
    action_d  = ActNone;
    fault_d   = 1'b0;
    state_d   = StDisabled;
    retry_inc = (retry_q != RetrySat) ? retry_q + 1'b1 : retry_q;

    if (s1_tick_q && delay_q != '0) begin
      delay_d = delay_q - 1'b1;
    end
    if (state_q != prev_q) begin
      if (state_q == StIdle) begin
        delay_d = clamp_delay(idle_delay_q);
      end else if (state_q == StWait) begin
        delay_d = clamp_delay(measure_delay_q);
      end
    end

    case (state_q)
      StIdle: begin
        state_d = (delay_d == '0) ? StStart : StIdle;
      end
      StStart: begin
        action_d = ActStart;
        state_d  = s1_bus_ok_q ? StWait : StError;
      end
      StWait: begin
        state_d = (delay_d == '0) ? StRead : StWait;
      end
      StRead: begin
        action_d = ActRead;
        state_d  = s1_bus_ok_q ? StCrc : StError;
      end
      StCrc: begin
        action_d = ActCrc;
        state_d  = s1_check_ok_q ? StCalc : StError;
      end
      StCalc: begin
        action_d = ActConvert;
        state_d  = s1_check_ok_q ? StIdle : StError;
      end
      StRestart: begin
        action_d = ActSoftReset;
        state_d  = StIdle;
      end
      StError: begin
        if (retry_inc < max_retries_q) begin
          retry_d = retry_inc;
          state_d = StRestart;
        end else begin
          retry_d = '0;
          fault_d = 1'b1;
          state_d = StDisabled;
        end
      end
      default: begin
        state_d = StDisabled;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      prev_q  <= StIdle;
      delay_q <= '0;
      retry_q <= '0;
    end else if (s1_adv) begin
      state_q <= state_d;
      prev_q  <= state_q;
      delay_q <= delay_d;
      retry_q <= retry_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      action_q    <= action_d;
      state_now_q <= state_d;
      fault_q     <= fault_d;
      disabled_q  <= (state_d == StDisabled);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign action_o       = action_q;
  assign state_now_o    = state_now_q;
  assign system_fault_o = fault_q;
  assign disabled_o     = disabled_q;

  a_fault_disables : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && system_fault_o |-> disabled_o)
    else $error("fault reported without halting");

  a_disabled_sticks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDisabled |=> state_q == StDisabled)
    else $error("left the disabled state");

  a_prev_tracks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> prev_q == $past(state_q))
    else $error("previous state not tracking");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(state_now_q))
    else $error("pending result overwritten");

endmodule
